// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the stack RTL; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(name, clk, rst, prop, msg)
`define ASSERT_NEVER(name, clk, rst, expr, msg)

`endif

`endif

// ----- hw/rtl/stk_pkg.sv -----
// Types and codes shared by the stack modules.
`default_nettype none

package stk_pkg;

   localparam int DATA_W = 32;

   // Request command codes
   localparam logic [2:0] CMD_PUSH   = 3'd0;
   localparam logic [2:0] CMD_POP    = 3'd1;
   localparam logic [2:0] CMD_SEARCH = 3'd2;
   localparam logic [2:0] CMD_READ   = 3'd3;
   localparam logic [2:0] CMD_STATUS = 3'd4;

   // Response status codes
   localparam logic [2:0] STS_OK       = 3'd0;
   localparam logic [2:0] STS_EMPTY    = 3'd1;
   localparam logic [2:0] STS_FULL     = 3'd2;
   localparam logic [2:0] STS_BADPOS   = 3'd3;
   localparam logic [2:0] STS_NOTFOUND = 3'd4;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } stk_state_type;

   typedef struct packed {
      logic [2:0]               status;
      logic signed [DATA_W-1:0] data_out;
   } stk_result_type;

endpackage

`default_nettype wire

// ----- hw/rtl/stk_mem.sv -----
// Stack storage: one write port, one read port with registered read data.
`default_nettype none

module stk_mem
   import stk_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire  [AW-1:0]            wr_addr,
   input  wire  signed [DATA_W-1:0] wr_data,
   input  wire                      rd_en,
   input  wire  [AW-1:0]            rd_addr,
   output logic signed [DATA_W-1:0] rd_data
);

   logic signed [DATA_W-1:0] store_ff [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/stk_ctrl.sv -----
// Stack sequencer: request latch, entry count, memory access and search walk.
`default_nettype none
`include "assert_macros.svh"

module stk_ctrl
   import stk_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int CNT_W = 7
) (
   input  wire                      clock,
   input  wire                      reset,
   // request side
   input  wire                      req_valid,
   output logic                     req_ready,
   input  wire  [2:0]               req_command,
   input  wire  signed [DATA_W-1:0] req_value,
   input  wire  [CNT_W-1:0]         req_position,
   // result side
   output logic                     res_valid,
   input  wire                      res_ready,
   output stk_result_type           res,
   output logic [CNT_W-1:0]         res_count,
   // memory side
   output logic                     mem_wr_en,
   output logic [AW-1:0]            mem_wr_addr,
   output logic signed [DATA_W-1:0] mem_wr_data,
   output logic                     mem_rd_en,
   output logic [AW-1:0]            mem_rd_addr,
   input  wire  signed [DATA_W-1:0] mem_rd_data
);

   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   stk_state_type            state_ff, state_in;
   logic [2:0]               cmd_ff;
   logic signed [DATA_W-1:0] val_ff;
   logic [CNT_W-1:0]         pos_ff;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [AW-1:0]            addr_ff;

   logic             accept;
   logic             commit;
   logic             step;
   logic             push_ok;
   logic [CNT_W-1:0] issue_idx;
   logic [CNT_W-1:0] count_after;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign commit    = res_valid && res_ready;

   // read address for a new word: top for pop and search, top-relative for read
   always_comb begin
      if (req_command == CMD_READ) begin
         issue_idx = count_ff - req_position;
      end else begin
         issue_idx = count_ff - CNT_ONE;
      end
   end

   // result and memory control
   always_comb begin
      res_valid    = 1'b0;
      res.status   = STS_OK;
      res.data_out = '0;
      count_after  = count_ff;
      push_ok      = 1'b0;
      step         = 1'b0;
      if (state_ff == ST_EXEC) begin
         case (cmd_ff)
            CMD_PUSH: begin
               res_valid = 1'b1;
               if (count_ff == CNT_FULL) begin
                  res.status = STS_FULL;
               end else begin
                  push_ok     = 1'b1;
                  count_after = count_ff + CNT_ONE;
               end
            end
            CMD_POP: begin
               res_valid = 1'b1;
               if (count_ff == '0) begin
                  res.status = STS_EMPTY;
               end else begin
                  res.data_out = mem_rd_data;
                  count_after  = count_ff - CNT_ONE;
               end
            end
            CMD_SEARCH: begin
               // one entry compared per cycle, top down
               if (count_ff == '0) begin
                  res_valid  = 1'b1;
                  res.status = STS_EMPTY;
               end else if (mem_rd_data == val_ff) begin
                  res_valid    = 1'b1;
                  res.data_out = val_ff;
               end else if (addr_ff == '0) begin
                  res_valid  = 1'b1;
                  res.status = STS_NOTFOUND;
               end else begin
                  step = 1'b1;
               end
            end
            CMD_READ: begin
               res_valid = 1'b1;
               if (count_ff == '0) begin
                  res.status = STS_EMPTY;
               end else if (pos_ff == '0 || pos_ff > count_ff) begin
                  res.status = STS_BADPOS;
               end else begin
                  res.data_out = mem_rd_data;
               end
            end
            default: begin
               res_valid = 1'b1;
            end
         endcase
      end
   end

   assign res_count   = count_after;
   assign count_in    = commit ? count_after : count_ff;
   assign mem_wr_en   = commit && push_ok;
   assign mem_wr_addr = count_ff[AW-1:0];
   assign mem_wr_data = val_ff;
   assign mem_rd_en   = accept || step;
   assign mem_rd_addr = step ? (addr_ff - AW'(1)) : issue_idx[AW-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // request word and walk address
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_command;
         val_ff <= req_value;
         pos_ff <= req_position;
      end
      if (mem_rd_en) begin
         addr_ff <= mem_rd_addr;
      end
   end

   `ASSERT_NEVER(a_count_bound, clock, reset, count_ff > CNT_FULL, "entry count above depth")

   `ASSERT_PROP(a_push_grows, clock, reset, mem_wr_en |=> count_ff == $past(count_ff) + CNT_ONE, "push did not grow count")

   `ASSERT_PROP(a_stall_holds, clock, reset, res_valid && !res_ready |=> state_ff == ST_EXEC && $stable(count_ff), "stalled result changed state")

endmodule

`default_nettype wire

// ----- hw/rtl/lifo_stack_with_search.sv -----
// LIFO stack with search: top level with response register.
//
// Requests arrive on the req_ channel (valid/ready), one word per request:
// command, value and 1-based position. Each request yields exactly one word
// on the rsp_ channel: status, data_out, entry_count and is_empty.
// Requests are handled one at a time. For push, pop, read and status the
// memory read is issued in the cycle the request is accepted and the result
// is evaluated in the next cycle. The result is then written to the response
// register; rsp_valid is set and req_ready comes back in the same cycle, so a
// new request is taken only once the last one has its result. A search walks
// the stack top down at one entry per cycle through the single memory read
// port and yields its result when an entry matches or the bottom entry has
// been compared, so it compares at most as many entries as the stack holds.
// The response register decouples the two sides: a new request is taken while
// a finished response waits; if rsp_ready stays low, the next request parks
// with its result until the register frees up.
// Reset (synchronous, active high) empties the stack and drops any pending
// response. Memory contents are not cleared; only entries below the count
// ever reach a response.
`default_nettype none

module lifo_stack_with_search
   import stk_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire  [2:0]                         req_command,
   input  wire  signed [DATA_W-1:0]           req_value,
   input  wire  [$clog2(DEPTH + 1)-1:0]       req_position,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [2:0]                         rsp_status,
   output logic signed [DATA_W-1:0]           rsp_data_out,
   output logic [$clog2(DEPTH + 1)-1:0]       rsp_entry_count,
   output logic                               rsp_is_empty
);

   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic                     res_valid;
   logic                     slot_free;
   stk_result_type           res;
   logic [CNT_W-1:0]         res_count;
   logic                     mem_wr_en;
   logic [AW-1:0]            mem_wr_addr;
   logic signed [DATA_W-1:0] mem_wr_data;
   logic                     mem_rd_en;
   logic [AW-1:0]            mem_rd_addr;
   logic signed [DATA_W-1:0] mem_rd_data;

   logic                     rsp_valid_ff, rsp_valid_in;
   stk_result_type           rsp_res_ff;
   logic [CNT_W-1:0]         rsp_count_ff;

   stk_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .req_value    (req_value),
      .req_position (req_position),
      .res_valid    (res_valid),
      .res_ready    (slot_free),
      .res          (res),
      .res_count    (res_count),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data),
      .mem_rd_en    (mem_rd_en),
      .mem_rd_addr  (mem_rd_addr),
      .mem_rd_data  (mem_rd_data)
   );

   stk_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // response register: free when empty or being drained this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      if (res_valid && slot_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && slot_free) begin
         rsp_res_ff   <= res;
         rsp_count_ff <= res_count;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_res_ff.status;
   assign rsp_data_out    = rsp_res_ff.data_out;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_empty    = (rsp_count_ff == '0);

endmodule

`default_nettype wire

// ----- tb/stack_tracker_pkg.sv -----
`timescale 1ns / 100ps
// Expected-response tracker for the LIFO stack: mirrors the stack and queues predicted words.

package stack_tracker_pkg;

   import stk_pkg::*;

   localparam int STACK_DEPTH = 64;
   localparam int POS_W       = $clog2(STACK_DEPTH + 1);

   typedef struct packed {
      logic [2:0]               status;
      logic signed [DATA_W-1:0] data_out;
      logic [POS_W-1:0]         entry_count;
      logic                     is_empty;
   } stack_rsp_type;

   class stack_tracker;

      logic signed [DATA_W-1:0] entries [STACK_DEPTH];
      int                       depth;
      stack_rsp_type            pending_rsps [$];
      int unsigned              errors;
      int unsigned              checked;
      int                       max_depth;
      int unsigned              status_hits [5];

      function new();
         depth     = 0;
         errors    = 0;
         checked   = 0;
         max_depth = 0;
         foreach (status_hits[i]) status_hits[i] = 0;
      endfunction

      function int pending();
         return pending_rsps.size();
      endfunction

      function logic signed [DATA_W-1:0] stored_word(int idx);
         return entries[idx];
      endfunction

      // Apply one accepted request to the mirror and queue the response it yields
      function void note_request(logic [2:0] cmd, logic signed [DATA_W-1:0] val,
                                 logic [POS_W-1:0] pos);
         stack_rsp_type rsp;
         int            i;
         bit            hit;
         rsp.status   = STS_OK;
         rsp.data_out = '0;
         hit          = 1'b0;
         case (cmd)
            CMD_PUSH: begin
               if (depth >= STACK_DEPTH) begin
                  rsp.status = STS_FULL;
               end else begin
                  entries[depth] = val;
                  depth++;
               end
            end
            CMD_POP: begin
               if (depth == 0) begin
                  rsp.status = STS_EMPTY;
               end else begin
                  depth--;
                  rsp.data_out = entries[depth];
               end
            end
            CMD_SEARCH: begin
               if (depth == 0) begin
                  rsp.status = STS_EMPTY;
               end else begin
                  // top down; first match ends the walk
                  for (i = depth - 1; i >= 0 && !hit; i--) begin
                     if (entries[i] == val) hit = 1'b1;
                  end
                  if (hit) rsp.data_out = val;
                  else rsp.status = STS_NOTFOUND;
               end
            end
            CMD_READ: begin
               if (depth == 0) begin
                  rsp.status = STS_EMPTY;
               end else if (pos == 0 || int'(pos) > depth) begin
                  rsp.status = STS_BADPOS;
               end else begin
                  rsp.data_out = entries[depth - int'(pos)];
               end
            end
            // status only, and the unused codes behave the same
            default: begin
            end
         endcase
         rsp.entry_count = POS_W'(depth);
         rsp.is_empty    = (depth == 0);
         if (depth > max_depth) max_depth = depth;
         pending_rsps.push_back(rsp);
      endfunction

      // Compare one response word against the oldest prediction
      function void check_response(logic [2:0] status, logic signed [DATA_W-1:0] data_out,
                                   logic [POS_W-1:0] entry_count, logic is_empty);
         stack_rsp_type want;
         if (pending_rsps.size() == 0) begin
            $error("response word with no request outstanding: status %0d data_out %0d",
                   status, data_out);
            errors++;
            return;
         end
         want = pending_rsps.pop_front();
         checked++;
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            errors++;
         end
         if (data_out !== want.data_out) begin
            $error("data_out: expected %0d, actual %0d", want.data_out, data_out);
            errors++;
         end
         if (entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", want.entry_count, entry_count);
            errors++;
         end
         if (is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, actual %0d", want.is_empty, is_empty);
            errors++;
         end
         if (want.status <= STS_NOTFOUND) status_hits[want.status]++;
      endfunction

   endclass

endpackage

// ----- tb/tb_lifo_stack_with_search.sv -----
`timescale 1ns / 100ps
// Top-level testbench for lifo_stack_with_search: stimulus, response sink and run control.

module tb_lifo_stack_with_search;

   import stk_pkg::*;
   import stack_tracker_pkg::*;

   localparam int RANDOM_PER_PHASE = 238;
   localparam int DRAIN_CYCLES     = 120;
   localparam int CYCLE_LIMIT      = 600000;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [2:0]               req_command;
   logic signed [DATA_W-1:0] req_value;
   logic [POS_W-1:0]         req_position;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [2:0]               rsp_status;
   logic signed [DATA_W-1:0] rsp_data_out;
   logic [POS_W-1:0]         rsp_entry_count;
   logic                     rsp_is_empty;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   int unsigned cycle_count   = 0;
   bit          fill_mode     = 1'b1;

   stack_tracker tracker = new();

   lifo_stack_with_search #(
      .DEPTH(STACK_DEPTH)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_value      (req_value),
      .req_position   (req_position),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_data_out   (rsp_data_out),
      .rsp_entry_count(rsp_entry_count),
      .rsp_is_empty   (rsp_is_empty)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Response sink: check words taken at this edge, then pick next ready
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            tracker.check_response(rsp_status, rsp_data_out, rsp_entry_count, rsp_is_empty);
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Present one request word, holding it until accepted
   task automatic send_word(logic [2:0] cmd, logic signed [DATA_W-1:0] val,
                            logic [POS_W-1:0] pos);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_value    <= val;
      req_position <= pos;
      do @(posedge clock); while (!req_ready);
      tracker.note_request(cmd, val, pos);
   endtask

   // Hold off the sender until every outstanding response is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   function automatic logic signed [DATA_W-1:0] random_word();
      case ($urandom_range(0, 9))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return '0;
         3: return -1;
         4, 5: return $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   // Build one random request, biased to fill or drain the stack
   task automatic random_request(output logic [2:0] cmd, output logic signed [DATA_W-1:0] val,
                                 output logic [POS_W-1:0] pos);
      int unsigned r;
      int          d;
      d = tracker.depth;
      if (fill_mode && d == STACK_DEPTH && $urandom_range(0, 3) == 0) fill_mode = 1'b0;
      if (!fill_mode && d == 0 && $urandom_range(0, 3) == 0) fill_mode = 1'b1;
      r = $urandom_range(0, 99);
      if (fill_mode) begin
         if (r < 60) cmd = CMD_PUSH;
         else if (r < 70) cmd = CMD_POP;
         else if (r < 82) cmd = CMD_SEARCH;
         else if (r < 94) cmd = CMD_READ;
         else cmd = 3'($urandom_range(CMD_STATUS, 7));
      end else begin
         if (r < 10) cmd = CMD_PUSH;
         else if (r < 65) cmd = CMD_POP;
         else if (r < 78) cmd = CMD_SEARCH;
         else if (r < 92) cmd = CMD_READ;
         else cmd = 3'($urandom_range(CMD_STATUS, 7));
      end
      // searches hit a stored word about half the time
      if (cmd == CMD_SEARCH && d > 0 && $urandom_range(0, 1) == 1)
         val = tracker.stored_word($urandom_range(0, d - 1));
      else
         val = random_word();
      case ($urandom_range(0, 9))
         0: pos = POS_W'($urandom_range(0, 127));
         1: pos = '0;
         2: pos = POS_W'(d);
         3: pos = POS_W'(d + 1);
         default: pos = (d > 0) ? POS_W'($urandom_range(1, d)) : POS_W'($urandom_range(0, 3));
      endcase
   endtask

   // Stimulus
   initial begin
      logic [2:0]               cmd;
      logic signed [DATA_W-1:0] val;
      logic [POS_W-1:0]         pos;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_command  <= CMD_STATUS;
      req_value    <= '0;
      req_position <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty stack, value extremes, zero search, position edges, unused codes
      send_word(CMD_STATUS, '0, '0);
      send_word(CMD_POP, '0, '0);
      send_word(CMD_SEARCH, '0, '0);
      send_word(CMD_READ, '0, 7'd1);
      send_word(CMD_PUSH, 32'sh8000_0000, '0);
      send_word(CMD_PUSH, 32'sh7fff_ffff, '0);
      send_word(CMD_PUSH, '0, '0);
      send_word(CMD_PUSH, -1, 7'd127);
      send_word(CMD_SEARCH, '0, '0);
      send_word(CMD_SEARCH, 32'sh8000_0000, '0);
      send_word(CMD_SEARCH, 32'sh0001_2345, '0);
      send_word(CMD_READ, '0, '0);
      send_word(CMD_READ, '0, 7'd5);
      send_word(CMD_READ, '0, 7'd4);
      send_word(CMD_READ, '0, 7'd1);
      send_word(CMD_READ, -1, 7'd127);
      send_word(3'd5, 32'sh5555_5555, 7'd42);
      send_word(3'd6, '0, '0);
      send_word(3'd7, -1, 7'd127);
      send_word(CMD_POP, '0, '0);
      send_word(CMD_POP, '0, '0);
      send_word(CMD_POP, '0, '0);
      send_word(CMD_POP, '0, '0);
      send_word(CMD_POP, '0, '0);
      send_word(CMD_STATUS, '0, '0);
      wait_drained();

      // Random phases: no idling, sender gaps, receiver stalls, both
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 52; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 52; end
            default: begin send_idle_pct = 11; stall_pct = 11; end
         endcase
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            random_request(cmd, val, pos);
            send_word(cmd, val, pos);
         end
         wait_drained();
      end

      stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d responses over directed and four gap/stall mixes; deepest stack %0d of %0d.",
               tracker.checked, tracker.max_depth, STACK_DEPTH);
      $display("Outcomes: ok %0d, empty %0d, full %0d, bad position %0d, not found %0d.",
               tracker.status_hits[STS_OK], tracker.status_hits[STS_EMPTY],
               tracker.status_hits[STS_FULL], tracker.status_hits[STS_BADPOS],
               tracker.status_hits[STS_NOTFOUND]);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
